// ===== rtl/scc_pkg.sv =====
// Shared widths, codes and control structs for the strong connectivity checker.
`default_nettype none

package scc_pkg;

  localparam int VC_W   = 7;
  localparam int VTX_W  = 7;
  localparam int KIND_W = 2;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ONE_WAY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TWO_WAY = 2'd2;

  typedef struct packed {
    logic init;
    logic issue;
    logic apply;
  } scc_front_ctl_t;

  typedef struct packed {
    logic pend_bit;
    logic any_pending;
    logic all_reached;
  } scc_front_sts_t;

endpackage

`default_nettype wire

// ===== rtl/scc_if.sv =====
// Valid/ready channel interfaces for the edge/evaluate input and the result output.
`default_nettype none

interface scc_in_if;
  import scc_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [VTX_W-1:0]  src_vertex;
  logic [VTX_W-1:0]  dst_vertex;
  logic [KIND_W-1:0] edge_kind;

  modport source (output valid, output cmd, output src_vertex, output dst_vertex,
                  output edge_kind, input ready);
  modport sink (input valid, input cmd, input src_vertex, input dst_vertex,
                input edge_kind, output ready);
endinterface

interface scc_out_if;
  logic valid;
  logic ready;
  logic connected;

  modport source (output valid, output connected, input ready);
  modport sink (input valid, input connected, output ready);
endinterface

`default_nettype wire

// ===== rtl/scc_frontier.sv =====
// Reached and pending vertex sets of one reachability walk.
`default_nettype none

module scc_frontier #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                               clk,
  input  scc_pkg::scc_front_ctl_t            ctl,
  input  logic [$clog2(MAX_VERTICES)-1:0]    idx,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]  n,
  input  logic [MAX_VERTICES-1:0]            row,
  output scc_pkg::scc_front_sts_t            sts
);
  import scc_pkg::*;

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

  logic [MAX_VERTICES-1:0] reached_r, reached_nxt;
  logic [MAX_VERTICES-1:0] pending_r, pending_nxt;
  logic [MAX_VERTICES-1:0] mask_r, mask_nxt;
  logic [MAX_VERTICES-1:0] new_bits;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      mask_nxt[i] = (CNT_W'(i) < n);
    end
    new_bits = ctl.apply ? (row & mask_r & ~reached_r) : '0;
    if (ctl.init) begin
      reached_nxt = ONE_BIT;
      pending_nxt = ONE_BIT;
    end else begin
      reached_nxt = reached_r | new_bits;
      pending_nxt = (pending_r & ~(ctl.issue ? (ONE_BIT << idx) : '0)) | new_bits;
    end
  end

  always_ff @(posedge clk) begin
    reached_r <= reached_nxt;
    pending_r <= pending_nxt;
    if (ctl.init) begin
      mask_r <= mask_nxt;
    end
  end

  assign sts.pend_bit    = pending_r[idx];
  assign sts.any_pending = |pending_r;
  assign sts.all_reached = &(reached_r | ~mask_r);

endmodule

`default_nettype wire

// ===== rtl/strong_connectivity_check_core.sv =====
// Strong connectivity checker over an adjacency bit matrix held in two row memories.
//
// Input channel in_chan carries one item per transfer: cmd 0 adds an edge
// (one-way or two-way), cmd 1 evaluates the loaded graph and clears it.
// Result channel out_chan carries one connected bit per evaluate item.
// The user must write the vertex count through cfg_we and cfg_wdata only while
// idle; the block itself does not enforce this. An edge transfer passes through
// EDGE1, and also EDGE2 for a two-way edge between distinct vertices; an ignored
// edge leaves the block idle. Each edge is a read-modify-write of one row in the
// forward and one row in the reverse memory, read through registered outputs.
// An evaluation of more than one vertex sweeps rows 0 to n-1 once per pass,
// repeating until no vertex is pending, first forward, then reverse if the
// forward walk reached every vertex. It then writes the result register and
// clears both memories; after reset the same clearing sweep runs before the
// first input transfer is taken. A stalled result holds in the output
// register; edge items are still taken, and a following evaluation waits
// for the output register to empty before it finishes.
`default_nettype none

module strong_connectivity_check_core #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  scc_in_if.sink                     in_chan,
  scc_out_if.source                  out_chan,
  input  logic                       cfg_we,
  input  logic [scc_pkg::VC_W-1:0]   cfg_wdata
);
  import scc_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W = (CNT_W > VTX_W) ? CNT_W : VTX_W;
  localparam logic [MAX_VERTICES-1:0] ONE_BIT = MAX_VERTICES'(1);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_EDGE1  = 8'b0000_0100,
    ST_EDGE2  = 8'b0000_1000,
    ST_WALK   = 8'b0001_0000,
    ST_DRAIN  = 8'b0010_0000,
    ST_CHECK  = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [VC_W-1:0]  vc_r;
  logic [CNT_W-1:0] n_cur;
  logic [IDX_W-1:0] src_idx_r, dst_idx_r;
  logic             two_way_r;
  logic [IDX_W-1:0] v_r;
  logic [IDX_W-1:0] clr_r;
  logic             dir_r;
  logic             pend_d_r;
  logic             result_r;
  logic             out_valid_r;
  logic             connected_r;

  logic [MAX_VERTICES-1:0] fwd_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rev_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] fwd_q, rev_q;
  logic                    fwd_we, rev_we;
  logic [IDX_W-1:0]        fwd_waddr, rev_waddr, fwd_raddr, rev_raddr;
  logic [MAX_VERTICES-1:0] fwd_wdata, rev_wdata;

  scc_front_ctl_t front_ctl;
  scc_front_sts_t front_sts;

  logic             in_acc;
  logic             src_ok, dst_ok, kind_ok, edge_ok;
  logic [IDX_W-1:0] in_src_idx, in_dst_idx;
  logic             last_v, last_clr, small_graph, out_free;

  assign n_cur = (CMP_W'(vc_r) < CMP_W'(MAX_VERTICES)) ? CNT_W'(vc_r)
                                                       : CNT_W'(MAX_VERTICES);

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign src_ok  = (in_chan.src_vertex != '0) &&
                   (CMP_W'(in_chan.src_vertex) <= CMP_W'(n_cur));
  assign dst_ok  = (in_chan.dst_vertex != '0) &&
                   (CMP_W'(in_chan.dst_vertex) <= CMP_W'(n_cur));
  assign kind_ok = (in_chan.edge_kind == KIND_ONE_WAY) ||
                   (in_chan.edge_kind == KIND_TWO_WAY);
  assign edge_ok = src_ok && dst_ok && kind_ok;

  assign in_src_idx = IDX_W'(in_chan.src_vertex - VTX_W'(1));
  assign in_dst_idx = IDX_W'(in_chan.dst_vertex - VTX_W'(1));

  assign last_v      = (CNT_W'(v_r) == (n_cur - CNT_W'(1)));
  assign last_clr    = (clr_r == IDX_W'(MAX_VERTICES - 1));
  assign small_graph = (n_cur <= CNT_W'(1));
  assign out_free    = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt       = state_r;
    fwd_we          = 1'b0;
    rev_we          = 1'b0;
    fwd_waddr       = clr_r;
    rev_waddr       = clr_r;
    fwd_wdata       = '0;
    rev_wdata       = '0;
    fwd_raddr       = v_r;
    rev_raddr       = v_r;
    front_ctl.init  = 1'b0;
    front_ctl.issue = 1'b0;
    front_ctl.apply = pend_d_r;
    case (state_r)
      ST_CLEAR: begin
        fwd_we = 1'b1;
        rev_we = 1'b1;
        if (last_clr) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        fwd_raddr = in_src_idx;
        rev_raddr = in_dst_idx;
        if (in_acc) begin
          if (in_chan.cmd == CMD_EVAL) begin
            if (small_graph) begin
              state_nxt = ST_RESULT;
            end else begin
              front_ctl.init = 1'b1;
              state_nxt      = ST_WALK;
            end
          end else if (edge_ok) begin
            state_nxt = ST_EDGE1;
          end
        end
      end
      ST_EDGE1: begin
        fwd_we    = 1'b1;
        rev_we    = 1'b1;
        fwd_waddr = src_idx_r;
        rev_waddr = dst_idx_r;
        fwd_wdata = fwd_q | (ONE_BIT << dst_idx_r);
        rev_wdata = rev_q | (ONE_BIT << src_idx_r);
        fwd_raddr = dst_idx_r;
        rev_raddr = src_idx_r;
        if (two_way_r && (src_idx_r != dst_idx_r)) begin
          state_nxt = ST_EDGE2;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EDGE2: begin
        fwd_we    = 1'b1;
        rev_we    = 1'b1;
        fwd_waddr = dst_idx_r;
        rev_waddr = src_idx_r;
        fwd_wdata = fwd_q | (ONE_BIT << src_idx_r);
        rev_wdata = rev_q | (ONE_BIT << dst_idx_r);
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        front_ctl.issue = 1'b1;
        if (last_v) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (front_sts.any_pending) begin
          state_nxt = ST_WALK;
        end else if (front_sts.all_reached && !dir_r) begin
          front_ctl.init = 1'b1;
          state_nxt      = ST_WALK;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fwd_we) begin
      fwd_mem[fwd_waddr] <= fwd_wdata;
    end
    fwd_q <= fwd_mem[fwd_raddr];
  end

  always_ff @(posedge clk) begin
    if (rev_we) begin
      rev_mem[rev_waddr] <= rev_wdata;
    end
    rev_q <= rev_mem[rev_raddr];
  end

  scc_frontier #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_frontier (
    .clk(clk),
    .ctl(front_ctl),
    .idx(v_r),
    .n  (n_cur),
    .row(dir_r ? rev_q : fwd_q),
    .sts(front_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      vc_r        <= '0;
      clr_r       <= '0;
      pend_d_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_d_r <= (state_r == ST_WALK) && front_sts.pend_bit;
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end else begin
        clr_r <= '0;
      end
      if ((state_r == ST_RESULT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && in_acc) begin
      src_idx_r <= in_src_idx;
      dst_idx_r <= in_dst_idx;
      two_way_r <= (in_chan.edge_kind == KIND_TWO_WAY);
      dir_r     <= 1'b0;
      v_r       <= '0;
      result_r  <= 1'b1;
    end
    if (state_r == ST_WALK) begin
      v_r <= last_v ? '0 : v_r + IDX_W'(1);
    end
    if ((state_r == ST_CHECK) && !front_sts.any_pending) begin
      if (!front_sts.all_reached) begin
        result_r <= 1'b0;
      end else if (!dir_r) begin
        dir_r <= 1'b1;
      end
    end
    if ((state_r == ST_RESULT) && out_free) begin
      connected_r <= result_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.connected = connected_r;

endmodule

`default_nettype wire

// ===== rtl/scc_checker.sv =====
// Port-level assertions for the strong connectivity checker and their bind.
`default_nettype none

module scc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_cmd,
  input logic out_valid,
  input logic out_ready,
  input logic out_connected
);
  import scc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_connected))
    else $error("Stalled result changed or vanished.");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_EVAL) |=> !in_ready)
    else $error("Input taken right after an evaluate transfer.");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !in_ready)
    else $error("Input ready before the clearing sweep after reset.");

  a_edge_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_EDGE) && !out_valid |=> !out_valid)
    else $error("Edge transfer produced a result.");

endmodule

bind strong_connectivity_check_core scc_checker u_scc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .in_cmd       (in_chan.cmd),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_connected(out_chan.connected)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the strong connectivity checker on random graphs.
module tb_top;
  import scc_pkg::*;

  localparam int MAXV          = 64;
  localparam int SETTLE_CYCLES = 2 * MAXV + 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 60000;
  localparam int ITEM_TARGET   = 850;

  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic              cmd;
    logic [VTX_W-1:0]  src;
    logic [VTX_W-1:0]  dst;
    logic [KIND_W-1:0] kind;
  } scc_item_t;

  typedef enum int {SHAPE_RING, SHAPE_BROKEN_RING, SHAPE_TREE, SHAPE_SCATTER} graph_shape_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [VC_W-1:0] cfg_wdata;

  scc_in_if  in_if();
  scc_out_if out_if();

  strong_connectivity_check_core #(
    .MAX_VERTICES(MAXV)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  scc_item_t       pending_items[$];
  scc_item_t       graph_batch[$];
  logic            expected_connected[$];
  logic [MAXV-1:0] graph_rows[MAXV];

  int   vertex_count_model = 0;
  int   fail_count = 0;
  int   counted_items = 0;
  int   applied_edges = 0;
  int   ignored_edges = 0;
  int   eval_count = 0;
  int   connected_count = 0;
  int   config_writes = 0;
  int   widest_count = 0;
  int   in_gap = 0;
  logic in_burst = 1'b0;
  int   out_stall = 0;
  logic out_burst = 1'b0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int vertices_in_use();
    return (vertex_count_model > MAXV) ? MAXV : vertex_count_model;
  endfunction

  // Grows the reached set from vertex 1 until it stops changing, following
  // edges forward or backward, and tells whether all n vertices were reached.
  function automatic logic reaches_all(int n, logic reverse);
    logic [MAXV-1:0] mask;
    logic [MAXV-1:0] seen;
    logic [MAXV-1:0] grown;
    logic            changed;
    int              v;
    mask = '0;
    for (v = 0; v < n; v++) mask[v] = 1'b1;
    seen = '0;
    seen[0] = 1'b1;
    changed = 1'b1;
    while (changed) begin
      grown = seen;
      for (v = 0; v < n; v++) begin
        if (!reverse && seen[v]) grown = grown | (graph_rows[v] & mask);
        if (reverse && (graph_rows[v] & seen) != '0) grown[v] = 1'b1;
      end
      changed = (grown != seen);
      seen = grown;
    end
    return (seen & mask) == mask;
  endfunction

  function automatic void update_graph(scc_item_t it);
    int   n;
    int   v;
    logic ok;
    n = vertices_in_use();
    if (it.cmd == CMD_EDGE) begin
      if (it.src == 0 || it.dst == 0 || it.src > n || it.dst > n ||
          !(it.kind == KIND_ONE_WAY || it.kind == KIND_TWO_WAY)) begin
        ignored_edges++;
      end else begin
        graph_rows[it.src - 1][it.dst - 1] = 1'b1;
        if (it.kind == KIND_TWO_WAY) graph_rows[it.dst - 1][it.src - 1] = 1'b1;
        applied_edges++;
      end
    end else begin
      ok = (n > 1) ? (reaches_all(n, 1'b0) && reaches_all(n, 1'b1)) : 1'b1;
      expected_connected.push_back(ok);
      for (v = 0; v < MAXV; v++) graph_rows[v] = '0;
      eval_count++;
    end
  endfunction

  function automatic int draw_gap(logic burst);
    if (burst) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
    return $urandom_range(0, 2);
  endfunction

  function automatic void queue_item(logic cmd, int s, int d, logic [KIND_W-1:0] kind);
    scc_item_t it;
    it.cmd  = cmd;
    it.src  = VTX_W'(s);
    it.dst  = VTX_W'(d);
    it.kind = kind;
    pending_items.push_back(it);
  endfunction

  // Adds one edge of a graph under construction, now and then followed by
  // an edge that the block has to ignore.
  function automatic void batch_edge(int n, int s, int d, logic [KIND_W-1:0] kind);
    scc_item_t it;
    scc_item_t junk;
    int        bad;
    it.cmd  = CMD_EDGE;
    it.src  = VTX_W'(s);
    it.dst  = VTX_W'(d);
    it.kind = kind;
    graph_batch.push_back(it);
    counted_items++;
    if ($urandom_range(0, 7) == 0) begin
      junk.cmd = CMD_EDGE;
      junk.src = VTX_W'($urandom_range(0, 127));
      junk.dst = VTX_W'($urandom_range(0, 127));
      if ($urandom_range(0, 1) == 1) begin
        junk.kind = ($urandom_range(0, 1) == 1) ? KIND_NONE : KIND_SPARE;
      end else begin
        junk.kind = ($urandom_range(0, 1) == 1) ? KIND_ONE_WAY : KIND_TWO_WAY;
        bad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(n + 1, 127);
        if ($urandom_range(0, 1) == 1) junk.src = VTX_W'(bad);
        else junk.dst = VTX_W'(bad);
      end
      graph_batch.push_back(junk);
      counted_items++;
    end
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    while (pending_items.size() != 0 || in_if.valid || expected_connected.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(int value);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[VC_W-1:0];
    vertex_count_model = value & 127;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    config_writes++;
    if (vertex_count_model > widest_count) widest_count = vertex_count_model;
  endtask

  always @(posedge clk) begin : drive_inputs
    scc_item_t accepted;
    scc_item_t next_item;
    logic      next_valid;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      next_valid = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        accepted.cmd  = in_if.cmd;
        accepted.src  = in_if.src_vertex;
        accepted.dst  = in_if.dst_vertex;
        accepted.kind = in_if.edge_kind;
        update_graph(accepted);
        next_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = draw_gap(in_burst);
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          in_if.cmd        <= next_item.cmd;
          in_if.src_vertex <= next_item.src;
          in_if.dst_vertex <= next_item.dst;
          in_if.edge_kind  <= next_item.kind;
          next_valid = 1'b1;
        end
      end
      in_if.valid <= next_valid;
    end
  end

  always @(posedge clk) begin : check_results
    logic want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_connected.size() == 0) begin
          $display("%0t: result transfer with none expected: expected none, got %0b",
                   $time, out_if.connected);
          fail_count++;
        end else begin
          want = expected_connected.pop_front();
          if (want !== out_if.connected) begin
            $display("%0t: connected mismatch: expected %0b, got %0b",
                     $time, want, out_if.connected);
            fail_count++;
          end
          if (out_if.connected === 1'b1) connected_count++;
        end
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        out_stall = draw_gap(out_burst);
      end
      if (hold_served != hold_requests) begin
        hold_left = HOLD_CYCLES;
        hold_served = hold_requests;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int           vc;
    int           n;
    int           graphs;
    int           i;
    int           j;
    int           k;
    int           pick;
    int           swap_v;
    int           skip;
    int           phase_no;
    int           perm[MAXV];
    scc_item_t    tmp;
    graph_shape_t shape;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.cmd = CMD_EDGE;
    in_if.src_vertex = '0;
    in_if.dst_vertex = '0;
    in_if.edge_kind = KIND_NONE;
    out_if.ready = 1'b0;
    for (i = 0; i < MAXV; i++) graph_rows[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With no vertices in use every graph counts as connected.
    queue_item(CMD_EVAL, 0, 0, KIND_NONE);
    queue_item(CMD_EDGE, 127, 127, KIND_SPARE);
    queue_item(CMD_EVAL, 127, 127, KIND_SPARE);

    set_vertex_count(1);
    queue_item(CMD_EDGE, 1, 1, KIND_ONE_WAY);
    queue_item(CMD_EVAL, 0, 0, KIND_NONE);

    set_vertex_count(2);
    queue_item(CMD_EDGE, 1, 2, KIND_ONE_WAY);
    queue_item(CMD_EVAL, 0, 0, KIND_NONE);
    queue_item(CMD_EDGE, 1, 2, KIND_TWO_WAY);
    queue_item(CMD_EVAL, 1, 2, KIND_ONE_WAY);
    queue_item(CMD_EDGE, 0, 1, KIND_TWO_WAY);
    queue_item(CMD_EDGE, 2, 1, KIND_SPARE);
    queue_item(CMD_EDGE, 2, 1, KIND_NONE);
    queue_item(CMD_EDGE, 1, 2, KIND_ONE_WAY);
    queue_item(CMD_EDGE, 2, 3, KIND_TWO_WAY);
    queue_item(CMD_EVAL, 2, 1, KIND_TWO_WAY);

    // The path reaches vertex 4, which is cut off before the evaluation.
    set_vertex_count(4);
    queue_item(CMD_EDGE, 1, 2, KIND_TWO_WAY);
    queue_item(CMD_EDGE, 2, 3, KIND_TWO_WAY);
    queue_item(CMD_EDGE, 3, 4, KIND_TWO_WAY);
    queue_item(CMD_EDGE, 1, 5, KIND_TWO_WAY);
    set_vertex_count(3);
    queue_item(CMD_EVAL, 0, 0, KIND_NONE);

    set_vertex_count(64);
    queue_item(CMD_EDGE, 1, 64, KIND_ONE_WAY);
    queue_item(CMD_EDGE, 64, 64, KIND_ONE_WAY);
    queue_item(CMD_EDGE, 65, 1, KIND_TWO_WAY);
    queue_item(CMD_EVAL, 64, 64, KIND_SPARE);

    phase_no = 0;
    while (counted_items < ITEM_TARGET) begin
      if (phase_no == 0) begin
        vc = 3;
      end else if (phase_no == 1) begin
        vc = 127;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 4) vc = $urandom_range(0, 1);
        else if (pick < 64) vc = $urandom_range(2, 8);
        else if (pick < 84) vc = $urandom_range(9, 24);
        else if (pick < 95) vc = $urandom_range(25, 64);
        else vc = $urandom_range(65, 127);
      end
      set_vertex_count(vc);
      n = (vc > MAXV) ? MAXV : vc;
      if (phase_no == 0) graphs = 6;
      else graphs = (n > 24) ? 1 : $urandom_range(1, 4);
      // The receiver holds off while several small graphs are offered.
      if (phase_no == 0) hold_requests++;

      for (k = 0; k < graphs; k++) begin
        for (i = 0; i < n; i++) perm[i] = i + 1;
        for (i = n - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          swap_v = perm[i];
          perm[i] = perm[j];
          perm[j] = swap_v;
        end
        shape = graph_shape_t'($urandom_range(0, 3));
        case (shape)
          SHAPE_RING, SHAPE_BROKEN_RING: begin
            skip = (shape == SHAPE_BROKEN_RING && n > 0) ? $urandom_range(0, n - 1) : -1;
            for (i = 0; i < n; i++)
              if (i != skip)
                batch_edge(n, perm[i], perm[(i + 1) % n],
                           ($urandom_range(0, 3) == 0) ? KIND_TWO_WAY : KIND_ONE_WAY);
          end
          SHAPE_TREE: begin
            for (i = 1; i < n; i++)
              batch_edge(n, perm[i], perm[$urandom_range(0, i - 1)],
                         ($urandom_range(0, 3) == 0) ? KIND_ONE_WAY : KIND_TWO_WAY);
          end
          default: begin
            if (n > 0)
              repeat ($urandom_range(0, 2 * n))
                batch_edge(n, $urandom_range(1, n), $urandom_range(1, n),
                           ($urandom_range(0, 1) == 1) ? KIND_TWO_WAY : KIND_ONE_WAY);
          end
        endcase
        if (n > 0)
          repeat ($urandom_range(0, n / 2))
            batch_edge(n, $urandom_range(1, n), $urandom_range(1, n),
                       ($urandom_range(0, 1) == 1) ? KIND_TWO_WAY : KIND_ONE_WAY);

        for (i = graph_batch.size() - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = graph_batch[i];
          graph_batch[i] = graph_batch[j];
          graph_batch[j] = tmp;
        end
        while (graph_batch.size() != 0) pending_items.push_back(graph_batch.pop_front());

        // Sometimes the last graph stays loaded across the next count change.
        if (k != graphs - 1 || $urandom_range(0, 9) != 0) begin
          queue_item(CMD_EVAL, $urandom_range(0, 127), $urandom_range(0, 127),
                     KIND_W'($urandom_range(0, 3)));
          counted_items++;
        end
      end
      phase_no++;
    end

    wait_idle();
    if (expected_connected.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_connected.size());
      fail_count++;
    end
    $display("Covered %0d applied and %0d ignored edge transfers, %0d evaluations, %0d connected.",
             applied_edges, ignored_edges, eval_count, connected_count);
    $display("The vertex count was written %0d times over %0d phases, up to %0d.",
             config_writes, phase_no, widest_count);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== strong_connectivity_check_core.f =====
rtl/scc_pkg.sv
rtl/scc_if.sv
rtl/scc_frontier.sv
rtl/strong_connectivity_check_core.sv
rtl/scc_checker.sv
sim/tb_top.sv
